>>> hdl/gvrm_pkg.sv
// ----------------------------------------------------------------------------
// gvrm_pkg
// Shared types and constants of the grid visited-region marker.
// ----------------------------------------------------------------------------
package gvrm_pkg;

    // Default sizes of the grid store and of the marking square.
    localparam int GRID_COLS_DEF  = 128;
    localparam int GRID_ROWS_DEF  = 128;
    localparam int MAX_RADIUS_DEF = 4;

    // Fixed field widths.
    localparam int CELL_W   = 8;
    localparam int POSE_W   = 24;
    localparam int COORD_W  = 7;
    localparam int THRESH_W = 16;
    localparam int RADIUS_W = 3;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 3;
    // A rounded pose lies in [-32768, 32768]; scan coordinates need 17 signed bits.
    localparam int CENTER_W = 17;

    // Input and output tdata widths.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    // Register reset values.
    localparam logic [7:0]          MAP_WIDTH_RST  = 8'd128;
    localparam logic [7:0]          MAP_HEIGHT_RST = 8'd128;
    localparam logic signed [7:0]   OCCUPIED_RST   = 8'sd100;
    localparam logic signed [7:0]   VISITED_RST    = -8'sd100;
    localparam logic [15:0]         THRESHOLD_RST  = 16'd256;
    localparam logic [2:0]          RADIUS_RST     = 3'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        REG_MAP_WIDTH  = 3'd0,
        REG_MAP_HEIGHT = 3'd1,
        REG_OCCUPIED   = 3'd2,
        REG_VISITED    = 3'd3,
        REG_THRESHOLD  = 3'd4,
        REG_RADIUS     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0]              map_width;
        logic [7:0]              map_height;
        logic signed [CELL_W-1:0] occupied_value;
        logic signed [CELL_W-1:0] visited_value;
        logic [THRESH_W-1:0]     change_threshold;
        logic [RADIUS_W-1:0]     mark_radius;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;     // input channel is open
        logic eval;     // test pose significance, update reference
        logic center;   // round pose to centre cell
        logic base;     // set up scan origin and counters
        logic rd;       // read the current grid cell
        logic check;    // mark the current cell if not occupied
        logic advance;  // step to the next cell of the square
        logic flush;    // send the held cell as the last one
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pose_in;      // a pose item is offered
        logic significant;
        logic span_zero;
        logic in_bounds;
        logic markable;
        logic stall;
        logic scan_last;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

>>> hdl/gvrm_grid_ram.sv
// ----------------------------------------------------------------------------
// gvrm_grid_ram
// Occupancy grid store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gvrm_grid_ram #(
    parameter int DEPTH = gvrm_pkg::GRID_COLS_DEF * gvrm_pkg::GRID_ROWS_DEF
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [$clog2(DEPTH)-1:0]            waddr,
    input  logic [gvrm_pkg::CELL_W-1:0]         wdata,
    input  logic                                re,
    input  logic [$clog2(DEPTH)-1:0]            raddr,
    output logic [gvrm_pkg::CELL_W-1:0]         rdata
);
    import gvrm_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/gvrm_ctrl.sv
// ----------------------------------------------------------------------------
// gvrm_ctrl
// Sequencer of the marker: pose evaluation, square scan and final flush.
// ----------------------------------------------------------------------------
module gvrm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  gvrm_pkg::sts_t  sts,
    output gvrm_pkg::cmd_t  cmd
);
    import gvrm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EVAL   = 7'b0000010,
        ST_CENTER = 7'b0000100,
        ST_BASE   = 7'b0001000,
        ST_READ   = 7'b0010000,
        ST_CHECK  = 7'b0100000,
        ST_FLUSH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.idle = 1'b1;
                if (sts.pose_in) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.significant ? ST_CENTER : ST_IDLE;
            end
            ST_CENTER: begin
                cmd.center = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.base   = 1'b1;
                state_next = sts.span_zero ? ST_FLUSH : ST_READ;
            end
            ST_READ: begin
                if (sts.in_bounds) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CHECK;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = sts.scan_last ? ST_FLUSH : ST_READ;
                end
            end
            ST_CHECK: begin
                // A new mark must wait until the held one can move to the output.
                if (!(sts.markable && sts.stall)) begin
                    cmd.check   = 1'b1;
                    cmd.advance = 1'b1;
                    state_next  = sts.scan_last ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/gvrm_datapath.sv
// ----------------------------------------------------------------------------
// gvrm_datapath
// Pose registers, scan counters, grid store access and output registers.
// ----------------------------------------------------------------------------
module gvrm_datapath #(
    parameter int GRID_COLS  = gvrm_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = gvrm_pkg::GRID_ROWS_DEF,
    parameter int MAX_RADIUS = gvrm_pkg::MAX_RADIUS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gvrm_pkg::cfg_t                     cfg,
    input  gvrm_pkg::cmd_t                     cmd,
    output gvrm_pkg::sts_t                     sts,
    input  logic                               s_tvalid,
    input  logic [gvrm_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [0:0]                         s_tuser,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [gvrm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast
);
    import gvrm_pkg::*;

    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int OFF_W = $clog2(2 * MAX_RADIUS);

    // Input item fields.
    logic [COORD_W-1:0]       in_col;
    logic [COORD_W-1:0]       in_row;
    logic [CELL_W-1:0]        in_value;
    logic signed [POSE_W-1:0] in_px;
    logic signed [POSE_W-1:0] in_py;
    logic                     accept;

    assign in_col   = s_tdata[6:0];
    assign in_row   = s_tdata[13:7];
    assign in_value = s_tdata[21:14];
    assign in_px    = s_tdata[45:22];
    assign in_py    = s_tdata[69:46];
    assign accept   = cmd.idle && s_tvalid;

    // Pose and reference.
    logic signed [POSE_W-1:0]   px_reg, py_reg;
    logic signed [POSE_W-1:0]   ref_x_reg, ref_y_reg;
    logic [POSE_W-1:0]          absx_reg, absy_reg;
    logic                       negx_reg, negy_reg;
    logic signed [CENTER_W-1:0] cx_reg, cy_reg;
    logic signed [CENTER_W-1:0] base_x_reg, base_y_reg;
    logic [OFF_W-1:0]           last_off_reg;
    logic [OFF_W-1:0]           i_reg, j_reg;

    logic signed [POSE_W:0] dx, dy;
    logic [POSE_W:0]        adx, ady;
    logic                   significant;

    always_comb begin
        dx  = $signed({px_reg[POSE_W-1], px_reg}) - $signed({ref_x_reg[POSE_W-1], ref_x_reg});
        dy  = $signed({py_reg[POSE_W-1], py_reg}) - $signed({ref_y_reg[POSE_W-1], ref_y_reg});
        adx = dx[POSE_W] ? $unsigned(-dx) : $unsigned(dx);
        ady = dy[POSE_W] ? $unsigned(-dy) : $unsigned(dy);
        significant = (adx > (POSE_W+1)'(cfg.change_threshold)) ||
                      (ady > (POSE_W+1)'(cfg.change_threshold));
    end

    // Rounding half away from zero: magnitude (|v| + 128) >> 8, sign restored.
    logic [POSE_W:0]   sum_x, sum_y;
    logic [CENTER_W-1:0] mag_x, mag_y;

    always_comb begin
        sum_x = {1'b0, absx_reg} + (POSE_W+1)'(128);
        sum_y = {1'b0, absy_reg} + (POSE_W+1)'(128);
        mag_x = sum_x[POSE_W:8];
        mag_y = sum_y[POSE_W:8];
    end

    // Effective radius and scan span.
    logic [RADIUS_W-1:0] r_eff;
    logic [RADIUS_W:0]   span;

    always_comb begin
        r_eff = (32'(cfg.mark_radius) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : cfg.mark_radius;
        span  = {r_eff, 1'b0};
    end

    // Current scan cell and bounds.
    logic signed [CENTER_W-1:0] vx, vy;
    logic [CENTER_W-1:0]        wlim, hlim;
    logic                       in_bounds;
    logic [AW-1:0]              scan_addr;

    always_comb begin
        vx   = base_x_reg + $signed({{(CENTER_W-OFF_W){1'b0}}, i_reg});
        vy   = base_y_reg + $signed({{(CENTER_W-OFF_W){1'b0}}, j_reg});
        wlim = (32'(cfg.map_width) < GRID_COLS) ? CENTER_W'(cfg.map_width)
                                                : CENTER_W'(GRID_COLS);
        hlim = (32'(cfg.map_height) < GRID_ROWS) ? CENTER_W'(cfg.map_height)
                                                 : CENTER_W'(GRID_ROWS);
        in_bounds = !vx[CENTER_W-1] && !vy[CENTER_W-1] &&
                    ($unsigned(vx) < wlim) && ($unsigned(vy) < hlim);
        scan_addr = AW'(32'(vy[ROW_W-1:0]) * GRID_COLS + 32'(vx[COL_W-1:0]));
    end

    // Grid store.
    logic [CELL_W-1:0] rdata;
    logic              load_we, mark_we, ram_we;
    logic [AW-1:0]     load_addr, ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              markable;

    always_comb begin
        load_we   = accept && !s_tuser[0] &&
                    (32'(in_col) < GRID_COLS) && (32'(in_row) < GRID_ROWS);
        load_addr = AW'(32'(in_row) * GRID_COLS + 32'(in_col));
        markable  = $signed(rdata) != cfg.occupied_value;
        mark_we   = cmd.check && markable;
        ram_we    = load_we || mark_we;
        ram_waddr = load_we ? load_addr : scan_addr;
        ram_wdata = load_we ? in_value : cfg.visited_value;
    end

    gvrm_grid_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (scan_addr),
        .rdata (rdata)
    );

    // Pose pipeline registers.
    always_ff @(posedge aclk) begin
        if (accept && s_tuser[0]) begin
            px_reg <= in_px;
            py_reg <= in_py;
        end
        if (cmd.eval) begin
            absx_reg <= px_reg[POSE_W-1] ? $unsigned(-px_reg) : $unsigned(px_reg);
            absy_reg <= py_reg[POSE_W-1] ? $unsigned(-py_reg) : $unsigned(py_reg);
            negx_reg <= px_reg[POSE_W-1];
            negy_reg <= py_reg[POSE_W-1];
        end
        if (cmd.center) begin
            cx_reg <= negx_reg ? -$signed(mag_x) : $signed(mag_x);
            cy_reg <= negy_reg ? -$signed(mag_y) : $signed(mag_y);
        end
        if (cmd.base) begin
            base_x_reg   <= cx_reg - $signed(CENTER_W'(r_eff));
            base_y_reg   <= cy_reg - $signed(CENTER_W'(r_eff));
            last_off_reg <= OFF_W'(span - (RADIUS_W+1)'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
        end else if (cmd.eval && significant) begin
            ref_x_reg <= px_reg;
            ref_y_reg <= py_reg;
        end
    end

    // Scan counters: columns outer, rows inner.
    logic scan_last;
    assign scan_last = (i_reg == last_off_reg) && (j_reg == last_off_reg);

    always_ff @(posedge aclk) begin
        if (cmd.base) begin
            i_reg <= '0;
            j_reg <= '0;
        end else if (cmd.advance) begin
            if (j_reg == last_off_reg) begin
                j_reg <= '0;
                i_reg <= i_reg + OFF_W'(1);
            end else begin
                j_reg <= j_reg + OFF_W'(1);
            end
        end
    end

    // One marked cell is held back until the next one or the scan end
    // decides its last flag.
    logic               pend_valid_reg, pend_valid_next;
    logic [COORD_W-1:0] pend_col_reg, pend_row_reg;
    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] m_col_reg, m_row_reg;
    logic               m_last_reg;
    logic               out_free, push_mid, push_last;

    always_comb begin
        out_free  = !m_valid_reg || m_tready;
        push_mid  = mark_we && pend_valid_reg;
        push_last = cmd.flush;

        m_valid_next = m_valid_reg && !m_tready;
        if (push_mid || push_last) begin
            m_valid_next = 1'b1;
        end

        pend_valid_next = pend_valid_reg;
        if (mark_we) begin
            pend_valid_next = 1'b1;
        end else if (push_last) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            pend_col_reg <= vx[COORD_W-1:0];
            pend_row_reg <= vy[COORD_W-1:0];
        end
        if (push_mid || push_last) begin
            m_col_reg  <= pend_col_reg;
            m_row_reg  <= pend_row_reg;
            m_last_reg <= push_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_row_reg, m_col_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        sts             = '0;
        sts.pose_in     = s_tvalid && s_tuser[0];
        sts.significant = significant;
        sts.span_zero   = (r_eff == '0);
        sts.in_bounds   = in_bounds;
        sts.markable    = markable;
        sts.stall       = pend_valid_reg && !out_free;
        sts.scan_last   = scan_last;
        sts.pend_valid  = pend_valid_reg;
        sts.out_free    = out_free;
    end

endmodule

>>> hdl/grid_visited_region_marker_core.sv
// ----------------------------------------------------------------------------
// grid_visited_region_marker_core
// Occupancy grid store that marks the cells around significant poses.
// ----------------------------------------------------------------------------
// Usage. The input channel (s_) carries two kinds of item, chosen by s_tuser.
// A load item (s_tuser = 0) writes one grid cell; loads may follow each
// other in every cycle while idle. A pose item (s_tuser = 1) is compared
// with the reference pose. If either axis moved by more than change_threshold
// it becomes the new reference, is rounded to a centre cell, and every
// in-bounds, non-occupied cell of the square around it is overwritten with
// visited_value and reported on the result channel (m_), columns outer, rows
// inner, with m_tlast on the final cell of the pose.
// Sequence. A pose is evaluated, rounded and set up; then each in-bounds cell
// of the square is read from the grid store and then compared and written
// back through its single write port, each out-of-bounds cell is only
// stepped over, and the last cell, if any, is then sent. An insignificant
// pose ends after its evaluation. Each result is held back until the next
// cell is marked or the scan ends, so that its last flag is known, and is
// then registered for output. A stalled receiver holds the scan once one
// result waits in the output register and one more is held.
// Reset clears the reference pose to zero and the registers to their defaults;
// grid contents are undefined until loaded.
// ----------------------------------------------------------------------------
module grid_visited_region_marker_core #(
    parameter int GRID_COLS  = gvrm_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = gvrm_pkg::GRID_ROWS_DEF,
    parameter int MAX_RADIUS = gvrm_pkg::MAX_RADIUS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [gvrm_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [gvrm_pkg::CFG_W-1:0]        cfg_wdata,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: cell_col[6:0], cell_row[13:7],
    // cell_value[21:14], pose_x[45:22], pose_y[69:46], zero fill [71:70].
    input  logic [gvrm_pkg::IN_TDATA_W-1:0]   s_tdata,
    // s_tuser fields from bit 0: action (0 load cell, 1 pose sample).
    input  logic [0:0]                        s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: marked_col[6:0], marked_row[13:7],
    // zero fill [15:14].
    output logic [gvrm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import gvrm_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    sts_t sts;

    // Register file. The user must write only while the block is idle, so a new
    // value never lands in the middle of a scan; the block does not enforce it.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAP_WIDTH:  cfg_next.map_width        = cfg_wdata[7:0];
                REG_MAP_HEIGHT: cfg_next.map_height       = cfg_wdata[7:0];
                REG_OCCUPIED:   cfg_next.occupied_value   = $signed(cfg_wdata[7:0]);
                REG_VISITED:    cfg_next.visited_value    = $signed(cfg_wdata[7:0]);
                REG_THRESHOLD:  cfg_next.change_threshold = cfg_wdata[THRESH_W-1:0];
                REG_RADIUS:     cfg_next.mark_radius      = cfg_wdata[RADIUS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_width        <= MAP_WIDTH_RST;
            cfg_reg.map_height       <= MAP_HEIGHT_RST;
            cfg_reg.occupied_value   <= OCCUPIED_RST;
            cfg_reg.visited_value    <= VISITED_RST;
            cfg_reg.change_threshold <= THRESHOLD_RST;
            cfg_reg.mark_radius      <= RADIUS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The sequencer opens the input channel only while idle.
    gvrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    gvrm_datapath #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign s_tready = cmd.idle;

endmodule

>>> tb/gvrm_tb_pkg.sv
// ----------------------------------------------------------------------------
// gvrm_tb_pkg
// Item kinds shared by the stimulus and the checker of the marker bench.
// ----------------------------------------------------------------------------
package gvrm_tb_pkg;

    // Kind of an input item, carried on s_tuser.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_POSE = 1'b1;

    // Cycles the block may still be busy after its last result has left.
    localparam int SETTLE_CYCLES = 200;

endpackage

>>> tb/visited_mark_checker.sv
// ----------------------------------------------------------------------------
// visited_mark_checker
// Watches both channels and the register port, keeps its own grid and
// reference pose, and compares every marked cell with the expected one.
// ----------------------------------------------------------------------------
module visited_mark_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gvrm_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [gvrm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // s_tdata fields from bit 0: cell_col, cell_row, cell_value, pose_x, pose_y.
    input  logic [gvrm_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: action.
    input  logic [0:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0: marked_col, marked_row.
    input  logic [gvrm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tlast,
    output int                               mismatches,
    output int                               marks_waiting,
    output int                               poses_seen,
    output int                               significant_poses,
    output int                               marks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import gvrm_pkg::*;
    import gvrm_tb_pkg::*;

    localparam int COLS = GRID_COLS_DEF;
    localparam int ROWS = GRID_ROWS_DEF;
    localparam int MAXR = MAX_RADIUS_DEF;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } mark_t;

    mark_t      pending_marks[$];
    logic [7:0] occupancy [COLS*ROWS];
    int         ref_x;
    int         ref_y;

    logic [7:0]          map_width;
    logic [7:0]          map_height;
    logic [7:0]          occupied_value;
    logic [7:0]          visited_value;
    logic [THRESH_W-1:0] change_threshold;
    logic [RADIUS_W-1:0] mark_radius;

    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic int round_to_cell(int v);
        if (v >= 0) begin
            return (v + 128) >>> 8;
        end
        return -((-v + 128) >>> 8);
    endfunction

    // Updates the reference pose and queues the cells that the pose marks.
    // The newest cell is held back one step so that the last flag is known.
    task automatic mark_around_pose(int px, int py);
        int    dx, dy, cx, cy, r, wl, hl, vx, vy, idx;
        bit    have_held;
        mark_t held;
        dx = px - ref_x;
        dy = py - ref_y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (!(dx > int'(change_threshold) || dy > int'(change_threshold))) begin
            return;
        end
        significant_poses++;
        ref_x = px;
        ref_y = py;
        cx = round_to_cell(px);
        cy = round_to_cell(py);
        r  = (int'(mark_radius) > MAXR) ? MAXR : int'(mark_radius);
        wl = (int'(map_width) < COLS) ? int'(map_width) : COLS;
        hl = (int'(map_height) < ROWS) ? int'(map_height) : ROWS;
        have_held = 1'b0;
        held = '0;
        for (vx = cx - r; vx < cx + r; vx++) begin
            for (vy = cy - r; vy < cy + r; vy++) begin
                if (vx < 0 || vx >= wl || vy < 0 || vy >= hl) continue;
                idx = vy * COLS + vx;
                if (occupancy[idx] == occupied_value) continue;
                occupancy[idx] = visited_value;
                if (have_held) pending_marks = {pending_marks, held};
                held.col  = vx[COORD_W-1:0];
                held.row  = vy[COORD_W-1:0];
                held.last = 1'b0;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_marks = {pending_marks, held};
        end
    endtask

    task automatic check_mark();
        mark_t want;
        if (pending_marks.size() == 0) begin
            flag_mismatch($sformatf("unexpected cell col %0d row %0d last %0d",
                m_tdata[6:0], m_tdata[13:7], m_tlast));
            return;
        end
        want = pending_marks.pop_front();
        marks_checked++;
        if (m_tdata[6:0] != want.col)
            flag_mismatch($sformatf("marked_col %0d, expected %0d", m_tdata[6:0], want.col));
        if (m_tdata[13:7] != want.row)
            flag_mismatch($sformatf("marked_row %0d, expected %0d", m_tdata[13:7], want.row));
        if (m_tlast != want.last)
            flag_mismatch($sformatf("last_marked %0d, expected %0d at col %0d row %0d",
                m_tlast, want.last, want.col, want.row));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ref_x            = 0;
            ref_y            = 0;
            map_width        = MAP_WIDTH_RST;
            map_height       = MAP_HEIGHT_RST;
            occupied_value   = OCCUPIED_RST;
            visited_value    = VISITED_RST;
            change_threshold = THRESHOLD_RST;
            mark_radius      = RADIUS_RST;
            pending_marks.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MAP_WIDTH:  map_width        = cfg_wdata[7:0];
                    REG_MAP_HEIGHT: map_height       = cfg_wdata[7:0];
                    REG_OCCUPIED:   occupied_value   = cfg_wdata[7:0];
                    REG_VISITED:    visited_value    = cfg_wdata[7:0];
                    REG_THRESHOLD:  change_threshold = cfg_wdata[THRESH_W-1:0];
                    REG_RADIUS:     mark_radius      = cfg_wdata[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == ACT_LOAD) begin
                    occupancy[int'(s_tdata[13:7]) * COLS + int'(s_tdata[6:0])] = s_tdata[21:14];
                end else begin
                    poses_seen++;
                    mark_around_pose(int'($signed(s_tdata[45:22])),
                                     int'($signed(s_tdata[69:46])));
                end
            end
            if (m_tvalid && m_tready) begin
                check_mark();
            end
        end
        marks_waiting = pending_marks.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the grid visited-region marker core.
// ----------------------------------------------------------------------------
// Two blocks of the grid store are loaded first: an 8 by 8 block at the
// origin and a 4 by 4 block at the far corner. Every pose and every map
// setting keeps the marked square inside loaded cells, so no marking pass
// ever reads a cell that was never loaded. A short directed part then covers
// the rounding rule, the threshold boundary, occupied cells, the grid corner,
// extreme poses, a zero and an oversized radius, an empty and an oversized
// map. Random phases follow under several register settings, with random
// idle bursts on both channels, one long hold-off of the receiver, and a
// final phase without any idling. The checker beside the block predicts and
// compares every marked cell; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gvrm_pkg::*;
    import gvrm_tb_pkg::*;

    // A hung run is stopped well after the slowest correct one would end.
    localparam int CYCLE_LIMIT = 1_500_000;
    // Length of the one long hold-off of the receiver.
    localparam int LONG_HOLD   = 400;
    // Side of the loaded block at the origin; random maps stay inside it.
    localparam int LOADED_SIDE = 8;
    // Side of the loaded block at the far corner of the store.
    localparam int CORNER_SIDE = 4;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_AW-1:0]      cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    // s_tdata fields from bit 0: cell_col, cell_row, cell_value, pose_x, pose_y.
    logic [IN_TDATA_W-1:0]  s_tdata;
    // s_tuser fields from bit 0: action.
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // m_tdata fields from bit 0: marked_col, marked_row.
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int mismatches;
    int marks_waiting;
    int poses_seen;
    int significant_poses;
    int marks_checked;

    // Stimulus state shared with the result sink.
    bit quiet;          // no idling on either side
    int hold_requests;  // each increment asks the sink for one long hold-off
    int settings_used;

    // The register values currently in force, mirrored for shaping stimulus.
    int cur_w, cur_h, cur_occ, cur_vis, cur_thr, cur_r;
    // Last pose offered, used to place poses right at the threshold.
    int last_px, last_py;

    grid_visited_region_marker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    visited_mark_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatches        (mismatches),
        .marks_waiting     (marks_waiting),
        .poses_seen        (poses_seen),
        .significant_poses (significant_poses),
        .marks_checked     (marks_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: ends the run if it goes on far longer than any correct one.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("grid_visited_region_marker_core test failed");
        $finish;
    end

    // Result sink. It stalls in short random bursts, sometimes runs freely
    // for a while, and serves one long hold-off on request. The hold-off is
    // counted here, so the sender keeps offering items meanwhile and the
    // block has to back up into its input channel.
    initial begin : result_sink
        int stall_left;
        int free_left;
        int holds_done;
        stall_left = 0;
        free_left  = 0;
        holds_done = 0;
        m_tready   = 1'b1;
        forever begin
            @(negedge aclk);
            if (holds_done != hold_requests) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet) begin
                    if (free_left > 0) begin
                        free_left--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 8);
                    end else if ($urandom_range(0, 19) == 0) begin
                        free_left = $urandom_range(20, 80);
                    end
                end
            end
        end
    end

    // Offers one item and returns once it has been taken. The handshake is
    // sampled at the rising edge; inputs only move at the falling edge. A
    // random idle burst may follow, so gaps land at every stage of a scan.
    task automatic send_item(logic kind, logic [IN_TDATA_W-1:0] data);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
    endtask

    // A load carries random junk in the pose fields, and a pose in the cell
    // fields, so that the unused bits of each kind toggle too.
    task automatic send_load(int col, int row, int value);
        logic [23:0] junk_x, junk_y;
        junk_x = 24'($urandom());
        junk_y = 24'($urandom());
        send_item(ACT_LOAD, {2'b00, junk_y, junk_x, 8'(value), 7'(row), 7'(col)});
    endtask

    task automatic send_pose(int x, int y);
        logic [23:0] px, py;
        logic [6:0]  junk_c, junk_r;
        logic [7:0]  junk_v;
        px = x[23:0];
        py = y[23:0];
        junk_c = 7'($urandom());
        junk_r = 7'($urandom());
        junk_v = 8'($urandom());
        last_px = int'($signed(px));
        last_py = int'($signed(py));
        send_item(ACT_POSE, {2'b00, py, px, junk_v, junk_r, junk_c});
    endtask

    // Loads a square block of the store with a mix of occupied, visited
    // and free values.
    task automatic preload_block(int col0, int row0, int side);
        int row, col, pick, value;
        for (row = row0; row < row0 + side; row++) begin
            for (col = col0; col < col0 + side; col++) begin
                pick = $urandom_range(0, 11);
                if (pick < 2) value = cur_occ;
                else if (pick < 3) value = cur_vis;
                else value = $urandom_range(0, 255);
                send_load(col, row, value);
            end
        end
    endtask

    // Waits until every expected cell has come out, then lets the block
    // finish any scan that produces nothing before the port is touched.
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (marks_waiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 16'(value);
    endtask

    // Writes all six registers back to back while the block is idle.
    task automatic apply_setting(int w, int h, int occ, int vis, int thr, int r);
        drain_block();
        write_reg(REG_MAP_WIDTH,  w & 8'hFF);
        write_reg(REG_MAP_HEIGHT, h & 8'hFF);
        write_reg(REG_OCCUPIED,   occ & 8'hFF);
        write_reg(REG_VISITED,    vis & 8'hFF);
        write_reg(REG_THRESHOLD,  thr & 16'hFFFF);
        write_reg(REG_RADIUS,     r & 3'h7);
        @(negedge aclk);
        cfg_we <= 1'b0;
        cur_w   = w;
        cur_h   = h;
        cur_occ = occ;
        cur_vis = vis;
        cur_thr = thr;
        cur_r   = r;
        settings_used++;
    endtask

    // Random traffic under the current setting. Most items are poses, many near
    // the map so that scans do real work; some sit exactly at or one past
    // the threshold, some jump anywhere in the pose range. Loads land inside
    // the map or one past its edge and often carry the occupied or visited value.
    task automatic random_traffic(int count);
        int i, pick, span_x, span_y, lim_c, lim_r, value, delta;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                lim_c = (cur_w > 127) ? 127 : cur_w;
                lim_r = (cur_h > 127) ? 127 : cur_h;
                pick = $urandom_range(0, 9);
                if (pick < 4) value = cur_occ;
                else if (pick < 6) value = cur_vis;
                else value = $urandom_range(0, 255);
                send_load($urandom_range(0, lim_c), $urandom_range(0, lim_r), value);
            end else if (pick < 44) begin
                send_pose(int'($urandom()), int'($urandom()));
            end else if (pick < 62) begin
                delta = cur_thr + int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1) delta = -delta;
                if ($urandom_range(0, 1) == 1) send_pose(last_px + delta, last_py);
                else send_pose(last_px, last_py + delta);
            end else begin
                span_x = ((cur_w > 128) ? 128 : cur_w) + 10;
                span_y = ((cur_h > 128) ? 128 : cur_h) + 10;
                send_pose(int'($urandom_range(0, span_x * 256)) - 5 * 256,
                          int'($urandom_range(0, span_y * 256)) - 5 * 256);
            end
        end
    endtask

    initial begin : stimulus
        // Every input is known from time zero, while reset is held low.
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_LOAD;
        quiet         = 1'b1;
        hold_requests = 0;
        settings_used = 0;
        last_px       = 0;
        last_py       = 0;
        cur_w   = MAP_WIDTH_RST;
        cur_h   = MAP_HEIGHT_RST;
        cur_occ = OCCUPIED_RST;
        cur_vis = VISITED_RST;
        cur_thr = THRESHOLD_RST;
        cur_r   = RADIUS_RST;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Load the block at the origin and the block at the far corner
        // back to back, without idling.
        preload_block(0, 0, LOADED_SIDE);
        preload_block(GRID_COLS_DEF - CORNER_SIDE, GRID_ROWS_DEF - CORNER_SIDE,
                      CORNER_SIDE);
        quiet = 1'b0;

        // Directed part under the reset setting: threshold of one cell and a
        // 2 by 2 square. A pose equal to the reference and a pose exactly at
        // the threshold are both insignificant.
        send_pose(0, 0);
        send_pose(256, 0);
        // Significant, but the square lies wholly above row zero: no cell.
        send_pose(257, -256);
        // Occupied cell inside the square is skipped; extreme cell values.
        send_load(5, 5, OCCUPIED_RST);
        send_load(4, 4, -128);
        send_load(4, 5, 127);
        send_pose(5 * 256, 5 * 256);
        // Halves round away from zero on both sides; just below half rounds down.
        send_pose(384, 384);
        send_pose(-384, 383);
        // Corner of the map; the square just fits inside the bounds.
        send_pose(127 * 256, 127 * 256);
        // Extremes of the pose range.
        send_pose(8388607, 8388607);
        send_pose(-8388608, -8388608);
        send_pose(-8388608, 8388607);

        // Zero radius: nothing is marked, yet the reference still moves, so
        // the small step after it is insignificant.
        apply_setting(128, 128, 100, -100, 256, 0);
        send_pose(10 * 256, 10 * 256);
        send_pose(10 * 256 + 100, 10 * 256);
        // Map height of zero marks nothing; the radius field above its limit.
        apply_setting(200, 0, 100, -100, 256, 7);
        send_pose(20 * 256, 20 * 256);
        // Width beyond the store and an oversized radius clamp to the limits:
        // the square around the far corner reaches the last column and row.
        apply_setting(255, 128, 100, -100, 256, 7);
        send_pose(128 * 256, 128 * 256);
        // Zero threshold: a repeated pose is insignificant, one step is not.
        apply_setting(LOADED_SIDE, LOADED_SIDE, 100, -100, 0, 1);
        send_pose(3 * 256, 3 * 256);
        send_pose(3 * 256, 3 * 256);
        send_pose(3 * 256 + 1, 3 * 256);

        // Random phases over several settings, extremes first. The map never
        // reaches past the loaded block at the origin.
        apply_setting(LOADED_SIDE, LOADED_SIDE, 100, -100, 256, 4);
        random_traffic(20);
        apply_setting(1, 1, -128, 127, 0, 2);
        random_traffic(20);
        apply_setting(LOADED_SIDE, 5, 127, -128, 65535, 3);
        random_traffic(20);

        // Full squares while the receiver holds off for a long stretch.
        apply_setting(LOADED_SIDE, LOADED_SIDE, $urandom_range(0, 255),
                      $urandom_range(0, 255), 64, 4);
        hold_requests++;
        random_traffic(20);
        apply_setting($urandom_range(0, LOADED_SIDE), $urandom_range(0, LOADED_SIDE),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 2048), $urandom_range(0, 7));
        random_traffic(15);

        // Last part: both sides run without idling.
        apply_setting(LOADED_SIDE, LOADED_SIDE, 0, -1, 128, 4);
        quiet = 1'b1;
        random_traffic(15);

        drain_block();
        $display("Covered %0d pose items, %0d of them significant, under %0d register settings.",
                 poses_seen, significant_poses, settings_used);
        $display("Checked %0d marked cells, including the map corner and one long receiver hold-off.",
                 marks_checked);
        if (mismatches == 0 && marks_waiting == 0) begin
            $display("grid_visited_region_marker_core test passed");
        end else begin
            $display("grid_visited_region_marker_core test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/gvrm_pkg.sv
hdl/gvrm_grid_ram.sv
hdl/gvrm_ctrl.sv
hdl/gvrm_datapath.sv
hdl/grid_visited_region_marker_core.sv
tb/gvrm_tb_pkg.sv
tb/visited_mark_checker.sv
tb/tb_top.sv
